### src/msci_pkg.sv
// msci_pkg: shared constants and types for the marching squares case index block
// no dependencies; used by the channel interfaces, the top level and its checker
package msci_pkg;

  localparam int MAX_GRID_COLS = 256;
  localparam int MAX_GRID_ROWS = 256;

  localparam int CHAN_W  = 8;
  localparam int CELL_W  = 8;
  localparam int CASE_W  = 4;
  localparam int SIZE_W  = 9;
  localparam int THR_W   = 8;
  localparam int COL_W   = $clog2(MAX_GRID_COLS + 1);
  localparam int ROW_W   = $clog2(MAX_GRID_ROWS + 1);
  localparam int LB_DEPTH = MAX_GRID_COLS + 1;
  localparam int SUM_W   = CHAN_W + 2;

  localparam int APB_AW  = 4;
  localparam int APB_DW  = 32;

  localparam logic [1:0] REG_GRID_COLS = 2'd0;
  localparam logic [1:0] REG_GRID_ROWS = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  localparam logic [SIZE_W-1:0] GRID_COLS_RST = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] GRID_ROWS_RST = SIZE_W'(256);
  localparam logic [THR_W-1:0]  THRESHOLD_RST = THR_W'(200);

  typedef struct packed {
    logic              res;
    logic [CELL_W-1:0] row;
    logic [CELL_W-1:0] col;
    logic              br;
    logic              bl;
  } lookup_stage_t;

endpackage

### src/msci_if.sv
// msci_if: valid/ready channel interfaces for grid-point pixels and cell results
// depends on msci_pkg for field widths
interface msci_pixel_if;
  import msci_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

interface msci_cell_if;
  import msci_pkg::*;
  logic              valid;
  logic              ready;
  logic [CELL_W-1:0] cell_row;
  logic [CELL_W-1:0] cell_col;
  logic [CASE_W-1:0] case_index;
  modport source (output valid, cell_row, cell_col, case_index, input ready);
  modport sink   (input valid, cell_row, cell_col, case_index, output ready);
endinterface

### src/marching_squares_case_index.sv
// marching_squares_case_index: thresholds grid-point pixels and emits cell case indexes
// depends on msci_pkg and the channel interfaces in msci_if.sv
// a result passes the lookup stage and output register after its bottom-right corner transaction
// one pixel per cycle unless result stalls; bit line buffer has one read and one write port
// reset: position, left bit and pipeline cleared, registers to defaults; the line buffer
//   is not cleared and the first point row never reads it for a result
module marching_squares_case_index (
  input  logic                       clk,
  input  logic                       rst,
  msci_pixel_if.sink                 pix,
  msci_cell_if.source                result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [msci_pkg::APB_AW-1:0] paddr,
  input  logic [msci_pkg::APB_DW-1:0] pwdata,
  output logic [msci_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import msci_pkg::*;

  logic [SIZE_W-1:0] grid_cols;
  logic [SIZE_W-1:0] grid_rows;
  logic [THR_W-1:0]  threshold;

  logic [ROW_W-1:0] point_row;
  logic [COL_W-1:0] point_col;
  logic             left_bit;
  logic             last_tr;

  logic             pend_valid;
  logic [COL_W-1:0] pend_addr;
  logic             pend_bit;

  logic          lb_mem [LB_DEPTH];
  logic          lb_rdata;
  logic          lb_we;
  logic [COL_W-1:0] lb_waddr;
  logic          lb_wdata;

  logic          s1_valid;
  lookup_stage_t s1;
  lookup_stage_t s1_next;
  logic          s1_adv;

  logic              out_valid;
  logic [CELL_W-1:0] out_row;
  logic [CELL_W-1:0] out_col;
  logic [CASE_W-1:0] out_case;

  logic              acc;
  logic              cfg_we;
  logic [COL_W-1:0]  cols_eff;
  logic [ROW_W-1:0]  rows_eff;
  logic [SUM_W-1:0]  pix_sum;
  logic [SUM_W-1:0]  pix_lim;
  logic              pix_bit;
  logic [ROW_W-1:0]  row_a;
  logic [ROW_W-1:0]  row_b;
  logic [ROW_W-1:0]  row_c;
  logic [COL_W-1:0]  col_c;
  logic [ROW_W-1:0]  row_inc;
  logic              col_last;

  // configuration port
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_cols <= GRID_COLS_RST;
      grid_rows <= GRID_ROWS_RST;
      threshold <= THRESHOLD_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_GRID_COLS: grid_cols <= pwdata[SIZE_W-1:0];
        REG_GRID_ROWS: grid_rows <= pwdata[SIZE_W-1:0];
        REG_THRESHOLD: threshold <= pwdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_GRID_COLS: prdata = APB_DW'(grid_cols);
      REG_GRID_ROWS: prdata = APB_DW'(grid_rows);
      REG_THRESHOLD: prdata = APB_DW'(threshold);
      default:       prdata = '0;
    endcase
  end

  // size clamping and pixel threshold: mean <= thr is sum <= 3*thr + 2
  always_comb begin
    if (grid_cols == '0)
      cols_eff = COL_W'(1);
    else if (grid_cols > SIZE_W'(MAX_GRID_COLS))
      cols_eff = COL_W'(MAX_GRID_COLS);
    else
      cols_eff = COL_W'(grid_cols);
    if (grid_rows == '0)
      rows_eff = ROW_W'(1);
    else if (grid_rows > SIZE_W'(MAX_GRID_ROWS))
      rows_eff = ROW_W'(MAX_GRID_ROWS);
    else
      rows_eff = ROW_W'(grid_rows);
  end

  assign pix_sum = SUM_W'(pix.red) + SUM_W'(pix.green) + SUM_W'(pix.blue);
  assign pix_lim = SUM_W'(threshold) + {1'b0, threshold, 1'b0} + SUM_W'(2);
  assign pix_bit = (pix_sum <= pix_lim);

  // effective position of the incoming point
  always_comb begin
    row_a = (point_row > rows_eff) ? '0 : point_row;
    row_b = ((ROW_W+1)'(row_a) + 1'b1 > (ROW_W+1)'(rows_eff)) ? '0 : row_a + 1'b1;
    if (point_col > cols_eff) begin
      col_c = '0;
      row_c = row_b;
    end else begin
      col_c = point_col;
      row_c = row_a;
    end
    row_inc  = ((ROW_W+1)'(row_c) + 1'b1 > (ROW_W+1)'(rows_eff)) ? '0 : row_c + 1'b1;
    col_last = (col_c >= cols_eff);
  end

  assign s1_adv    = s1_valid && (!s1.res || !out_valid || result.ready);
  assign pix.ready = !rst && (!s1_valid || s1_adv);
  assign acc       = pix.valid && pix.ready;

  always_comb begin
    s1_next.res = (col_c != '0) && (row_c != '0);
    s1_next.row = CELL_W'(row_c - 1'b1);
    s1_next.col = CELL_W'(col_c - 1'b1);
    s1_next.br  = pix_bit;
    s1_next.bl  = left_bit;
  end

  // line buffer write: left neighbor on the fly, row-end point from a register in the next cycle
  always_comb begin
    if (acc && (col_c != '0)) begin
      lb_we    = 1'b1;
      lb_waddr = col_c - 1'b1;
      lb_wdata = left_bit;
    end else begin
      lb_we    = pend_valid;
      lb_waddr = pend_addr;
      lb_wdata = pend_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (lb_we) lb_mem[lb_waddr] <= lb_wdata;
    if (acc) lb_rdata <= lb_mem[col_c];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_row  <= '0;
      point_col  <= '0;
      left_bit   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= acc && col_last;
      if (acc) begin
        if (col_last) begin
          left_bit  <= 1'b0;
          point_col <= '0;
          point_row <= row_inc;
        end else begin
          left_bit  <= pix_bit;
          point_col <= col_c + 1'b1;
          point_row <= row_c;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && col_last) begin
      pend_addr <= col_c;
      pend_bit  <= pix_bit;
    end
  end

  // lookup stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      last_tr   <= 1'b0;
    end else begin
      if (acc)
        s1_valid <= 1'b1;
      else if (s1_adv)
        s1_valid <= 1'b0;
      if (s1_adv)
        last_tr <= lb_rdata;
      if (s1_adv && s1.res)
        out_valid <= 1'b1;
      else if (result.ready)
        out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) s1 <= s1_next;
    if (s1_adv && s1.res) begin
      out_row  <= s1.row;
      out_col  <= s1.col;
      out_case <= {last_tr, lb_rdata, s1.br, s1.bl};
    end
  end

  assign result.valid      = out_valid;
  assign result.cell_row   = out_row;
  assign result.cell_col   = out_col;
  assign result.case_index = out_case;

endmodule

### src/msci_checker.sv
// msci_checker: port-level assertions for marching_squares_case_index
// depends on msci_pkg; attached to the top level by the bind at the end of this file
module msci_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [msci_pkg::CELL_W-1:0] out_row,
  input logic [msci_pkg::CELL_W-1:0] out_col,
  input logic [msci_pkg::CASE_W-1:0] out_case
);
  import msci_pkg::*;

  // a result stays until its transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_row) && $stable(out_col) && $stable(out_case))
    else $error("result payload changed while stalled");

  // a new result must be matched by an earlier input transaction
  a_out_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a matching input transaction");

  a_reset_clear: assert property (@(posedge clk)
    rst |-> !in_ready ##1 !out_valid)
    else $error("input ready in reset or output valid after reset");

endmodule

bind marching_squares_case_index msci_checker u_msci_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_row   (result.cell_row),
  .out_col   (result.cell_col),
  .out_case  (result.case_index)
);
